@@ design/periodic_task_tick_scheduler_core_assert.svh @@
// Assertion macros for the periodic task tick scheduler core.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptts assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PTTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptts assertion failed");

`endif

@@ design/ptts_pkg.sv @@
// Shared types and constants of the periodic task tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int HANDLE_W       = 16;
  localparam int PERIOD_W       = 16;
  localparam int ARG_W          = 32;
  localparam int COUNT_W        = 32;
  localparam int SLOT_W         = 3;
  localparam int OP_W           = 2;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 56;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  localparam logic KIND_IMMEDIATE = 1'b0;
  localparam logic KIND_PERIODIC  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [HANDLE_W-1:0] handle;
    logic [ARG_W-1:0]    argument;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

@@ design/periodic_task_tick_scheduler_core.sv @@
// Periodic task tick scheduler: a slot table, a sequencer and a shared remainder unit.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_tick_scheduler_core_assert.svh"
// A table of SLOT_COUNT periodic tasks. A tick word (tuser 0) bumps the
// 32-bit tick counter and fires every occupied slot whose nonzero period
// divides the new count, in slot order, one result word each with tlast on
// the final one; a tick that fires nothing gives no word. An add word (tuser 1)
// gives one immediate result naming the slot it lands in, or SLOT_COUNT when
// the table is full. A delete word (tuser 2) frees the first slot with that
// handle and gives no result. The block takes one input word at a time.
// A tick tests each occupied slot with a nonzero period in turn, through
// the single 32-step remainder unit, then gives one result word per fire.
// A stalled receiver holds the sequencer back. The result sits in an
// output register, so the next word is taken while it waits.
module periodic_task_tick_scheduler_core #(
  parameter int SLOT_COUNT = ptts_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // task_handle [15:0], period [31:16], argument [63:32]
  input  wire logic [ptts_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation [1:0]
  input  wire logic [ptts_pkg::OP_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // fired_handle [15:0], fired_argument [47:16], slot [50:48], zero [55:51]
  output logic [ptts_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // kind [0]
  output logic [0:0]                            m_tuser,
  output logic                                  m_tlast
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CHECK,
    S_WAIT,
    S_EMIT
  } state_t;

  state_t state;

  // Slot table and request holding registers
  logic [ptts_pkg::HANDLE_W-1:0] slot_handle   [SLOT_COUNT];
  logic [ptts_pkg::PERIOD_W-1:0] slot_period   [SLOT_COUNT];
  logic [ptts_pkg::ARG_W-1:0]    slot_argument [SLOT_COUNT];
  logic [ptts_pkg::COUNT_W-1:0]  tick_count;
  logic [ptts_pkg::HANDLE_W-1:0] req_handle;
  logic [ptts_pkg::PERIOD_W-1:0] req_period;
  logic [ptts_pkg::ARG_W-1:0]    req_argument;
  logic [IDX_W-1:0]              idx;
  logic [SLOT_COUNT-1:0]         fire_mask;

  // Input word fields
  logic [ptts_pkg::HANDLE_W-1:0] in_handle;
  logic [ptts_pkg::PERIOD_W-1:0] in_period;
  logic [ptts_pkg::ARG_W-1:0]    in_argument;
  logic                          in_accept;

  // Search results
  logic                          free_hit;
  logic [IDX_W-1:0]              free_idx;
  logic                          del_hit;
  logic [IDX_W-1:0]              del_idx;
  logic                          emit_hit;
  logic [IDX_W-1:0]              emit_idx;
  logic [SLOT_COUNT-1:0]         mask_after;
  logic                          armed;

  // Remainder unit and output stage hookup
  logic                          rem_start;
  logic                          rem_busy;
  logic                          rem_done;
  logic                          rem_zero;
  logic                          push;
  logic                          push_ready;
  ptts_pkg::result_t             push_word;
  ptts_pkg::result_t             out_word;

  assign in_handle   = s_tdata[15:0];
  assign in_period   = s_tdata[31:16];
  assign in_argument = s_tdata[63:32];
  assign s_tready    = (state == S_IDLE) && !rst;
  assign in_accept   = s_tvalid && s_tready;

  // Find the first empty slot and the first slot matching the delete handle
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    del_hit  = 1'b0;
    del_idx  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_hit && slot_handle[i] == '0) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (!del_hit && slot_handle[i] == in_handle) begin
        del_hit = 1'b1;
        del_idx = IDX_W'(i);
      end
    end
  end

  // Pick the lowest pending fire and what remains after it
  always_comb begin
    emit_hit   = 1'b0;
    emit_idx   = '0;
    mask_after = fire_mask;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!emit_hit && fire_mask[i]) begin
        emit_hit      = 1'b1;
        emit_idx      = IDX_W'(i);
        mask_after[i] = 1'b0;
      end
    end
  end

  assign armed     = (slot_handle[idx] != '0) && (slot_period[idx] != '0);
  assign rem_start = (state == S_CHECK) && armed;

  // Build the result word for the current state
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    case (state)
      S_ADD: begin
        push               = 1'b1;
        push_word.kind     = ptts_pkg::KIND_IMMEDIATE;
        push_word.handle   = req_handle;
        push_word.argument = req_argument;
        push_word.slot     = free_hit ? ptts_pkg::SLOT_W'(free_idx)
                                      : ptts_pkg::SLOT_W'(SLOT_COUNT);
        push_word.last     = 1'b1;
      end
      S_EMIT: begin
        push               = emit_hit;
        push_word.kind     = ptts_pkg::KIND_PERIODIC;
        push_word.handle   = slot_handle[emit_idx];
        push_word.argument = slot_argument[emit_idx];
        push_word.slot     = ptts_pkg::SLOT_W'(emit_idx);
        push_word.last     = (mask_after == '0);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Sequencer: take a word, test slots one by one, emit fires in order
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      idx        <= '0;
      fire_mask  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (ptts_pkg::op_t'(s_tuser))
              ptts_pkg::OP_TICK: begin
                tick_count <= tick_count + ptts_pkg::COUNT_W'(1);
                idx        <= '0;
                fire_mask  <= '0;
                state      <= S_CHECK;
              end
              ptts_pkg::OP_ADD: begin
                state <= S_ADD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (armed) begin
            state <= S_WAIT;
          end else if (idx == IDX_W'(SLOT_COUNT - 1)) begin
            state <= S_EMIT;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (rem_done) begin
            fire_mask[idx] <= rem_zero;
            if (idx == IDX_W'(SLOT_COUNT - 1)) begin
              state <= S_EMIT;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_CHECK;
            end
          end
        end
        S_EMIT: begin
          if (!emit_hit) begin
            state <= S_IDLE;
          end else if (push_ready) begin
            fire_mask <= mask_after;
            if (mask_after == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the add request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_handle   <= in_handle;
      req_period   <= in_period;
      req_argument <= in_argument;
    end
  end

  // Slot table: store on add, clear handle and period on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_handle[i] <= '0;
      end
    end else if (state == S_ADD && push_ready && free_hit) begin
      slot_handle[free_idx]   <= req_handle;
      slot_period[free_idx]   <= req_period;
      slot_argument[free_idx] <= req_argument;
    end else if (in_accept && ptts_pkg::op_t'(s_tuser) == ptts_pkg::OP_DELETE
                 && del_hit) begin
      slot_handle[del_idx] <= '0;
      slot_period[del_idx] <= '0;
    end
  end

  ptts_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (tick_count),
    .divisor  (slot_period[idx]),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  ptts_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .push_ready (push_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_word   (out_word)
  );

  assign m_tdata = {5'd0, out_word.slot, out_word.argument, out_word.handle};
  assign m_tuser = out_word.kind;
  assign m_tlast = out_word.last;

  // No input is taken while the remainder unit runs
  `PTTS_ASSERT_NOW(a_busy_not_ready, rem_busy, !s_tready)
  // A finished remainder only arrives while the sequencer waits for it
  `PTTS_ASSERT_NOW(a_done_in_wait, rem_done, state == S_WAIT)
  // An immediate fire is always the only result of its add
  `PTTS_ASSERT_NOW(a_add_last, m_tvalid && m_tuser[0] == ptts_pkg::KIND_IMMEDIATE, m_tlast)
  // An accepted add keeps the input closed for its result cycle
  `PTTS_ASSERT_NEXT(a_add_busy, in_accept && s_tuser == ptts_pkg::OP_ADD, !s_tready)

endmodule
`default_nettype wire

@@ design/ptts_rem.sv @@
// Shared bit-serial remainder unit: one restoring step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptts_rem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ptts_pkg::COUNT_W-1:0]  dividend,
  input  wire logic [ptts_pkg::PERIOD_W-1:0] divisor,
  output logic                               busy,
  output logic                               done,
  output logic                               rem_zero
);

  localparam int STEP_W = $clog2(ptts_pkg::COUNT_W);

  logic [ptts_pkg::PERIOD_W-1:0] rem;
  logic [ptts_pkg::PERIOD_W-1:0] rem_next;
  logic [ptts_pkg::COUNT_W-1:0]  dvd;
  logic [ptts_pkg::PERIOD_W-1:0] dvs;
  logic [STEP_W-1:0]             step;
  logic [ptts_pkg::PERIOD_W:0]   trial;
  logic                          take;

  // Shift in one dividend bit, subtract when the trial reaches the divisor
  always_comb begin
    trial    = {rem, dvd[ptts_pkg::COUNT_W-1]};
    take     = trial >= {1'b0, dvs};
    rem_next = take ? ptts_pkg::PERIOD_W'(trial - {1'b0, dvs})
                    : trial[ptts_pkg::PERIOD_W-1:0];
  end

  // Control: run one step per cycle, flag done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(ptts_pkg::COUNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[ptts_pkg::COUNT_W-2:0], 1'b0};
    end
  end

  assign rem_zero = (rem == '0);

endmodule
`default_nettype wire

@@ design/ptts_out_reg.sv @@
// Output register stage for result words, decoupling the sequencer from the sink.
`timescale 1ns / 1ps
`default_nettype none
module ptts_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ptts_pkg::result_t push_word,
  output logic                   push_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ptts_pkg::result_t      out_word
);

  assign push_ready = !out_valid || out_ready;

  // Hold the word until taken, load a new one when the stage frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_ready) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      out_word <= push_word;
    end
  end

endmodule
`default_nettype wire
